// ===== rtl/hcbd_pkg.sv =====
// Shared types, character codes and helpers for the chunked body decoder.
package hcbd_pkg;

  // Width of the chunk size and the per-chunk byte counter
  localparam int LEN_BITS = 32;
  // Width of the body total and the limit register
  localparam int BODY_W = 32;
  // Width used to compare a chunk size against the room left
  localparam int CMP_W = (LEN_BITS > BODY_W) ? LEN_BITS : BODY_W;

  localparam logic [BODY_W-1:0] MAX_BODY_RESET = BODY_W'(1048576);

  // Characters of the size line grammar
  localparam logic [7:0] CH_HT   = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_F = 8'h66;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_OK        = 2'd1,
    ST_BAD       = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_DATA_CR = 3'd2,
    PH_DATA_LF = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    status_t    status;
    logic       byte_ignored;
  } result_t;

  // Decode one hex digit: bit 4 flags a digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] off;
    off = 8'd0;
    hex_value = 5'd0;
    if (c inside {[CH_0:CH_9]}) begin
      off = c - CH_0;
      hex_value = {1'b1, off[3:0]};
    end else if (c inside {[CH_LA:CH_LF_F]}) begin
      off = c - CH_LA + 8'd10;
      hex_value = {1'b1, off[3:0]};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      off = c - CH_UA + 8'd10;
      hex_value = {1'b1, off[3:0]};
    end
  endfunction

  // Space and the control characters tab through carriage return
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c inside {[CH_HT:CH_CR], CH_SP});
  endfunction

endpackage

// ===== rtl/hcbd_channels.sv =====
// Valid/ready channel interfaces for raw bytes, decoded results and the limit register.
interface hcbd_raw_if;
  logic       valid;
  logic       ready;
  logic       start_message;
  logic [7:0] in_byte;
  modport source (output valid, output start_message, output in_byte, input ready);
  modport sink (input valid, input start_message, input in_byte, output ready);
endinterface

interface hcbd_body_if import hcbd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_valid;
  status_t    status;
  logic       byte_ignored;
  modport source (output valid, output body_byte, output body_valid, output status,
                  output byte_ignored, input ready);
  modport sink (input valid, input body_byte, input body_valid, input status,
                input byte_ignored, output ready);
endinterface

interface hcbd_cfg_if import hcbd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BODY_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder_unit.sv =====
// Chunked transfer body decoder: one raw byte in, one result out per request.
//
// Usage:
//   raw  : sink of the raw chunked stream, one byte per request; start_message
//          clears the decoder and the body total before that byte is parsed.
//   body : one result per raw request: the data byte with body_valid, the
//          running status (pending, ok, bad request, payload too large) and
//          byte_ignored for bytes that arrive after a final status.
//   cfg  : write of max_body_bytes, always ready; user must write only while idle; the block does not enforce it.
// Timing: the result of a request is registered. One request is taken every
//   cycle while the skid entry is empty; the state update is a single pass of
//   logic on the accepted byte and the parser registers, with the size-line
//   limit check (one 32-bit subtract and compare) as its longest path.
// Stall: an output register and one skid entry sit behind the parser; while
//   body stalls, one more request is taken into the skid entry, then raw.ready
//   drops until the output register drains.
// Reset: rst (synchronous) sets max_body_bytes to 1048576, returns the parser
//   to the size line with a pending status and empties both result entries.
module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  hcbd_raw_if.sink     raw,
  hcbd_body_if.source  body,
  hcbd_cfg_if.sink     cfg
);

  // Parser registers
  phase_t              phase, phase_next;
  logic [LEN_BITS-1:0] chunk_length, chunk_length_next;
  logic [LEN_BITS-1:0] data_left, data_left_next;
  logic [BODY_W-1:0]   body_total, body_total_next;
  logic                cr_pending, cr_pending_next;
  logic                line_nonempty, line_nonempty_next;
  logic                in_extension, in_extension_next;
  logic                bad_digit, bad_digit_next;
  status_t             final_status, final_status_next;
  logic [BODY_W-1:0]   max_body_bytes;

  // Parser state as seen after an optional start of message
  phase_t              cur_phase;
  logic [LEN_BITS-1:0] cur_chunk_length;
  logic [LEN_BITS-1:0] cur_data_left;
  logic [BODY_W-1:0]   cur_body_total;
  logic                cur_cr_pending;
  logic                cur_line_nonempty;
  logic                cur_in_extension;
  logic                cur_bad_digit;
  status_t             cur_final_status;

  // Result buffering
  result_t res_new, res_out, res_skid;
  logic    out_valid, skid_valid;

  logic [7:0]        b;
  logic [4:0]        hex;
  logic [BODY_W-1:0] room;
  logic              too_large;
  logic              push, pop;

  assign b    = raw.in_byte;
  assign hex  = hex_value(b);
  assign push = raw.valid && raw.ready;
  assign pop  = out_valid && body.ready;

  assign raw.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  // Clear the message state when the request opens a new message
  always_comb begin
    cur_phase         = phase;
    cur_chunk_length  = chunk_length;
    cur_data_left     = data_left;
    cur_body_total    = body_total;
    cur_cr_pending    = cr_pending;
    cur_line_nonempty = line_nonempty;
    cur_in_extension  = in_extension;
    cur_bad_digit     = bad_digit;
    cur_final_status  = final_status;
    if (raw.start_message) begin
      cur_phase         = PH_SIZE;
      cur_chunk_length  = '0;
      cur_data_left     = '0;
      cur_body_total    = '0;
      cur_cr_pending    = 1'b0;
      cur_line_nonempty = 1'b0;
      cur_in_extension  = 1'b0;
      cur_bad_digit     = 1'b0;
      cur_final_status  = ST_PENDING;
    end
  end

  // Check the new chunk against the room left under the limit
  assign room      = max_body_bytes - cur_body_total;
  assign too_large = (cur_body_total > max_body_bytes) ||
                     (CMP_W'(cur_chunk_length) > CMP_W'(room));

  // Next parser state
  always_comb begin
    phase_next         = cur_phase;
    chunk_length_next  = cur_chunk_length;
    data_left_next     = cur_data_left;
    body_total_next    = cur_body_total;
    cr_pending_next    = cur_cr_pending;
    line_nonempty_next = cur_line_nonempty;
    in_extension_next  = cur_in_extension;
    bad_digit_next     = cur_bad_digit;
    final_status_next  = cur_final_status;
    case (cur_phase)
      PH_SIZE: begin
        if (cur_cr_pending && b == CH_LF) begin
          // End of the size line
          cr_pending_next = 1'b0;
          if (!cur_line_nonempty || cur_bad_digit) begin
            final_status_next = ST_BAD;
            phase_next        = PH_DONE;
          end else if (cur_chunk_length == '0) begin
            phase_next = PH_TRAILER;
          end else if (too_large) begin
            final_status_next = ST_TOO_LARGE;
            phase_next        = PH_DONE;
          end else begin
            body_total_next = cur_body_total + BODY_W'(cur_chunk_length);
            data_left_next  = cur_chunk_length;
            phase_next      = PH_DATA;
          end
        end else begin
          // A lone CR counts as content and as whitespace
          if (cur_cr_pending) begin
            line_nonempty_next = 1'b1;
          end
          if (b == CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            cr_pending_next    = 1'b0;
            line_nonempty_next = 1'b1;
            if (!cur_in_extension && !cur_bad_digit) begin
              if (b == CH_SEMI) begin
                in_extension_next = 1'b1;
              end else if (hex[4]) begin
                if (|cur_chunk_length[LEN_BITS-1 -: 4]) begin
                  bad_digit_next = 1'b1;
                end else begin
                  chunk_length_next = {cur_chunk_length[LEN_BITS-5:0], hex[3:0]};
                end
              end else if (!is_space(b)) begin
                bad_digit_next = 1'b1;
              end
            end
          end
        end
      end
      PH_DATA: begin
        data_left_next = cur_data_left - LEN_BITS'(1);
        if (cur_data_left == LEN_BITS'(1)) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (b == CH_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          final_status_next = ST_BAD;
          phase_next        = PH_DONE;
        end
      end
      PH_DATA_LF: begin
        if (b == CH_LF) begin
          // Open the next size line
          phase_next         = PH_SIZE;
          chunk_length_next  = '0;
          cr_pending_next    = 1'b0;
          line_nonempty_next = 1'b0;
          in_extension_next  = 1'b0;
          bad_digit_next     = 1'b0;
        end else begin
          final_status_next = ST_BAD;
          phase_next        = PH_DONE;
        end
      end
      PH_TRAILER: begin
        if (cur_cr_pending && b == CH_LF) begin
          cr_pending_next   = 1'b0;
          final_status_next = ST_OK;
          phase_next        = PH_DONE;
        end else begin
          cr_pending_next = (b == CH_CR);
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // Result fields for the request
  always_comb begin
    res_new              = '0;
    res_new.status       = final_status_next;
    case (cur_phase)
      PH_DATA: begin
        res_new.body_byte  = b;
        res_new.body_valid = 1'b1;
      end
      PH_SIZE, PH_DATA_CR, PH_DATA_LF, PH_TRAILER: begin
        res_new.body_valid = 1'b0;
      end
      default: begin
        res_new.byte_ignored = 1'b1;
      end
    endcase
  end

  // Advance the parser on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      chunk_length  <= '0;
      data_left     <= '0;
      body_total    <= '0;
      cr_pending    <= 1'b0;
      line_nonempty <= 1'b0;
      in_extension  <= 1'b0;
      bad_digit     <= 1'b0;
      final_status  <= ST_PENDING;
    end else if (push) begin
      phase         <= phase_next;
      chunk_length  <= chunk_length_next;
      data_left     <= data_left_next;
      body_total    <= body_total_next;
      cr_pending    <= cr_pending_next;
      line_nonempty <= line_nonempty_next;
      in_extension  <= in_extension_next;
      bad_digit     <= bad_digit_next;
      final_status  <= final_status_next;
    end
  end

  // Take limit register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= MAX_BODY_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_body_bytes <= cfg.data;
    end
  end

  // Hold results in the output register, spill into the skid entry on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      res_out <= skid_valid ? res_skid : res_new;
    end else if (push) begin
      res_skid <= res_new;
    end
  end

  assign body.valid        = out_valid;
  assign body.body_byte    = res_out.body_byte;
  assign body.body_valid   = res_out.body_valid;
  assign body.status       = res_out.status;
  assign body.byte_ignored = res_out.byte_ignored;

  // The skid entry only fills behind a held output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  // The message is finished exactly when a final status is set
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) == (final_status != ST_PENDING))
    else $error("done phase and final status disagree");

  // A data phase always has bytes left to pass
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_left != '0))
    else $error("data phase with no bytes left");

  // Data bytes are only passed while the message is still pending
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_out.body_valid) |-> (res_out.status == ST_PENDING && !res_out.byte_ignored))
    else $error("data byte delivered with a final status");

endmodule
